FILE: src/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with search.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed transaction field widths
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int ITEM_W   = 32;
    localparam int OCC_W    = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_BACK  = 3'd3,
        REQ_SEARCH    = 3'd4,
        REQ_LIST      = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,   // keep contents
        CELL_SHR,    // take left neighbour (front insert)
        CELL_SHL,    // take right neighbour (front removal)
        CELL_ROT,    // rotate occupied cells one place towards the front
        CELL_PUT     // cell at index == fill takes the new value (back insert)
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ROT,
        ST_SEARCH,
        ST_LIST,
        ST_EXEC
    } ctrl_state_t;

endpackage

FILE: src/deq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: valid/ready handshake with request type and value.
// ----------------------------------------------------------------------------
interface deq_req_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

FILE: src/deq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_rsp_if
// Result channel: valid/ready handshake with status, position, item, fill and last.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [POS_W-1:0]           position;
    logic signed [ITEM_W-1:0]   item_out;
    logic [OCC_W-1:0]           occupancy;
    logic                       last;

    modport source (output valid, output status, output position, output item_out,
                    output occupancy, output last, input ready);
    modport sink   (input valid, input status, input position, input item_out,
                    input occupancy, input last, output ready);
endinterface

FILE: src/deque_with_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_top
// Bounded double-ended queue of words held in a chain of cells, with search
// and listing.
//
// Usage:
//  - req channel carries one request per transaction (insert front/back,
//    remove front/back, search, list) and a value; rsp channel returns
//    result transactions with status, position, item, occupancy and last.
//  - Cell 0 is the front. Front insert/remove shifts the whole chain by one
//    place; back insert writes the cell at the fill index; back removal
//    first rotates the occupied cells (fill - 1) places.
//  - Search and listing cost one rotation step per stored element; listing
//    gives one element per cycle while the receiver takes them. One request
//    is worked at a time.
//  - A result register sits on rsp: a new request is taken while the last
//    result still waits. When the receiver stalls, the sequencer waits
//    before producing the next result (listing simply pauses its walk).
//  - Request codes six and seven produce no result and change nothing.
//  - Reset empties the queue at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
module deque_with_search_top #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    deq_req_if.sink       req,
    deq_rsp_if.source     rsp
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // chain contents, index 0 = front
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    cell_op_t              cell_op;
    logic [DATA_WIDTH-1:0] cell_value;
    logic [CNT_W-1:0]      fill;
    logic [CNT_W-1:0]      tail;

    deq_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .req_type   (req.req_type),
        .value      (req.value),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .status     (rsp.status),
        .position   (rsp.position),
        .item_out   (rsp.item_out),
        .occupancy  (rsp.occupancy),
        .last       (rsp.last),
        .head_data  (cell_data[0]),
        .cell_op    (cell_op),
        .cell_value (cell_value),
        .fill       (fill),
        .tail       (tail)
    );

    // Each cell sees its two neighbours; the front cell takes the new value
    // on a front insert, the rear cell feeds itself on a shift towards front.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_front
            assign left_data = cell_value;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_rear
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .DEPTH      (DEPTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .value      (cell_value),
            .left_data  (left_data),
            .right_data (right_data),
            .head_data  (cell_data[0]),
            .fill       (fill),
            .tail       (tail),
            .data       (cell_data[i])
        );
    end

endmodule

FILE: src/deq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the chain; index 0 is the front of the queue.
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic                          clk,
    input  deq_pkg::cell_op_t             op,
    input  logic [DATA_WIDTH-1:0]         value,
    input  logic [DATA_WIDTH-1:0]         left_data,
    input  logic [DATA_WIDTH-1:0]         right_data,
    input  logic [DATA_WIDTH-1:0]         head_data,
    input  logic [$clog2(DEPTH+1)-1:0]    fill,
    input  logic [$clog2(DEPTH+1)-1:0]    tail,
    output logic [DATA_WIDTH-1:0]         data
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_HOLD: data_next = data_reg;
            CELL_SHR:  data_next = left_data;
            CELL_SHL:  data_next = right_data;
            CELL_ROT:
            begin
                if (IDX < tail)
                    data_next = right_data;
                else if (IDX == tail)
                    data_next = head_data;   // wrap of the front into the tail
            end
            CELL_PUT:
            begin
                if (IDX == fill)
                    data_next = value;
            end
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: src/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer, fill/step counters and result register.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH      = deq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [deq_pkg::REQ_W-1:0]         req_type,
    input  logic signed [deq_pkg::VALUE_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [deq_pkg::STATUS_W-1:0]      status,
    output logic [deq_pkg::POS_W-1:0]         position,
    output logic signed [deq_pkg::ITEM_W-1:0] item_out,
    output logic [deq_pkg::OCC_W-1:0]         occupancy,
    output logic                              last,
    input  logic [DATA_WIDTH-1:0]             head_data,
    output deq_pkg::cell_op_t                 cell_op,
    output logic [DATA_WIDTH-1:0]             cell_value,
    output logic [$clog2(DEPTH+1)-1:0]        fill,
    output logic [$clog2(DEPTH+1)-1:0]        tail
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    ctrl_state_t           state_reg, state_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  found_reg, found_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [POS_W-1:0]      position_reg, position_next;
    logic [ITEM_W-1:0]     item_reg, item_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic                  load_out;
    logic [CNT_W-1:0]      step_inc;

    assign out_free = !out_valid_reg || out_ready;
    assign step_inc = step_reg + 1'b1;
    assign tail     = count_reg - 1'b1;
    assign fill     = count_reg;
    assign cell_value = value_reg;

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        in_ready      = 1'b0;
        cell_op       = CELL_HOLD;
        load_out      = 1'b0;
        status_next   = status_reg;
        position_next = '0;
        item_next     = '0;
        last_next     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next   = req_type;
                    value_next = DATA_WIDTH'(value);
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                step_next  = '0;
                pos_next   = '0;
                found_next = 1'b0;
                case (req_reg)
                    REQ_INS_FRONT, REQ_INS_BACK, REQ_REM_FRONT:
                        state_next = ST_EXEC;
                    REQ_REM_BACK:
                        state_next = (count_reg > CNT_W'(1)) ? ST_ROT : ST_EXEC;
                    REQ_SEARCH:
                        state_next = (count_reg != '0) ? ST_SEARCH : ST_EXEC;
                    REQ_LIST:
                        state_next = (count_reg != '0) ? ST_LIST : ST_EXEC;
                    default:
                        state_next = ST_IDLE;   // unused request codes: no result
                endcase
            end

            // bring the back element to the front, order otherwise kept
            ST_ROT:
            begin
                cell_op   = CELL_ROT;
                step_next = step_inc;
                if (step_inc == tail)
                    state_next = ST_EXEC;
            end

            // full rotation restores the order
            ST_SEARCH:
            begin
                cell_op   = CELL_ROT;
                step_next = step_inc;
                if (!found_reg && (head_data == value_reg))
                begin
                    found_next = 1'b1;
                    pos_next   = step_inc;
                end
                if (step_inc == count_reg)
                    state_next = ST_EXEC;
            end

            ST_LIST:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    cell_op     = CELL_ROT;
                    step_next   = step_inc;
                    status_next = STAT_OK;
                    item_next   = ITEM_W'(head_data);
                    last_next   = (step_inc == count_reg);
                    if (step_inc == count_reg)
                        state_next = ST_IDLE;
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    case (req_reg)
                        REQ_INS_FRONT, REQ_INS_BACK:
                        begin
                            if (count_reg == FULL)
                                status_next = STAT_OVERFLOW;
                            else
                            begin
                                status_next = STAT_OK;
                                cell_op     = (req_reg == REQ_INS_FRONT) ? CELL_SHR : CELL_PUT;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        REQ_REM_FRONT, REQ_REM_BACK:
                        begin
                            if (count_reg == '0)
                                status_next = STAT_UNDERFLOW;
                            else
                            begin
                                status_next = STAT_OK;
                                item_next   = ITEM_W'(head_data);
                                cell_op     = CELL_SHL;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                                status_next = STAT_UNDERFLOW;
                            else if (found_reg)
                            begin
                                status_next   = STAT_OK;
                                position_next = POS_W'(pos_reg);
                            end
                            else
                                status_next = STAT_NOT_FOUND;
                        end
                        default:
                            status_next = STAT_UNDERFLOW;   // listing of an empty queue
                    endcase
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        occ_next = OCC_W'(count_next);

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        value_reg <= value_next;
        step_reg  <= step_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        if (load_out)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            item_reg     <= item_next;
            occ_reg      <= occ_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign item_out  = item_reg;
    assign occupancy = occ_reg;
    assign last      = last_reg;

endmodule

FILE: src/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [deq_pkg::STATUS_W-1:0]      status,
    input  logic [deq_pkg::POS_W-1:0]         position,
    input  logic [deq_pkg::OCC_W-1:0]         occupancy,
    input  logic                              last
);
    import deq_pkg::*;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
        && $stable(occupancy) && $stable(last))
        else $error("result changed while stalled");

    // a match position only on a successful, single search result
    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (position != '0) |-> (status == STAT_OK) && last)
        else $error("position reported without success");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_UNDERFLOW) |-> (occupancy == '0) && last
        && (position == '0))
        else $error("underflow with non-empty queue");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_OVERFLOW) |-> (occupancy == OCC_W'(DEPTH)) && last)
        else $error("overflow with queue not full");

endmodule

bind deque_with_search_top deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .position  (rsp.position),
    .occupancy (rsp.occupancy),
    .last      (rsp.last)
);
